FILE: hw/rtl/texture_header_validator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the texture header validator
// Shared property forms, clocked on i_clk with the active-low reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_HEADER_VALIDATOR_UNIT_ASSERT_SVH
`define TEXTURE_HEADER_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication outside reset.
`define THV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("texture header validator check failed");

// Next-cycle implication outside reset.
`define THV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("texture header validator check failed");

// Condition that must hold in the cycle after a reset edge.
`define THV_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("texture header validator reset check failed");

`endif

FILE: hw/rtl/thv_pkg.sv
// ----------------------------------------------------------------------------
// thv_pkg
// Types and constants shared by the texture header validator modules.
// ----------------------------------------------------------------------------
package thv_pkg;

    localparam int HEADER_BYTES = 40;
    localparam int MAX_EXTENT   = 65536;
    localparam int BLOCK_EDGE   = 4;
    localparam int CUBE_FACES   = 6;
    localparam int MAX_LEVELS   = 17;

    localparam int IN_W     = 384;
    localparam int OUT_W    = 56;
    localparam int STATUS_W = 4;
    localparam int WANTED_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam int EXT_W   = $clog2(MAX_EXTENT + 1);
    localparam int LVL_W   = $clog2(MAX_LEVELS + 1);
    localparam int PROD_W  = 2 * EXT_W;
    localparam int SUM_W   = PROD_W + 4 + $clog2(MAX_LEVELS + 1);
    localparam int WANT_W  = SUM_W + 3;

    localparam int BLOCK_SHIFT       = $clog2(BLOCK_EDGE);
    localparam int BLOCK_BYTES_SHIFT = 4;
    localparam int HALF_BYTES_SHIFT  = 3;
    localparam int PLAIN_BYTES_SHIFT = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 4'd0,
        ST_SHORT   = 4'd1,
        ST_MAGIC   = 4'd2,
        ST_VERSION = 4'd3,
        ST_EMPTY   = 4'd4,
        ST_FORMAT  = 4'd5,
        ST_FACES   = 4'd6,
        ST_SQUARE  = 4'd7,
        ST_LEVELS  = 4'd8,
        ST_LARGE   = 4'd9,
        ST_SIZE    = 4'd10
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC   = 3'd0,
        REG_VERSION = 3'd1,
        REG_HIGHEST = 3'd2,
        REG_BLOCK   = 3'd3,
        REG_HALF    = 3'd4
    } t_reg;

    typedef enum logic [1:0] {
        K_PLAIN = 2'd0,
        K_HALF  = 2'd1,
        K_BLOCK = 2'd2
    } t_kind;

    typedef struct packed {
        t_status           status;
        t_kind             kind;
        logic              cube;
        logic [LVL_W-1:0]  levels;
        logic [EXT_W-1:0]  width;
        logic [EXT_W-1:0]  height;
        logic [63:0]       have;
        logic [63:0]       declared;
    } t_job;

endpackage

FILE: hw/rtl/texture_header_validator_unit.sv
// ----------------------------------------------------------------------------
// texture_header_validator_unit
// Checks one texture header beat against the file length and returns a
// status code with the expected payload byte count.
// ----------------------------------------------------------------------------
// Usage: write the five setup registers through the cfg channel while idle.
// Each s_axis beat carries one header and the total file length; each
// m_axis beat returns the status code and the expected payload bytes.
// An accepted beat goes straight into a two-entry job queue, and the back
// end takes it from there once it is idle. A header that fails an early
// check goes from the queue to the done state and on to the result beat.
// A passed header walks the mip chain one level per cycle through a single
// multiplier, with L mip levels, at most 17, then drains, scales and
// compares. The back end handles one header at a time and takes the next
// only after handing over its last result; that loop sets the throughput.
// When m_axis stalls, the result beat holds, the back end waits with its
// next result, and s_axis keeps taking beats until the queue is full.
// Reset restores the register defaults, empties the queue and drops any
// pending result.
// ----------------------------------------------------------------------------
module texture_header_validator_unit
    import thv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // file_bytes[63:0], header_magic[95:64], header_version[127:96],
    // image_width[159:128], image_height[191:160], level_count[223:192],
    // format_code[255:224], color_space_code[287:256], faces[319:288],
    // declared_payload[383:320]
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status[3:0], wanted_bytes[51:4], zero fill [55:52]
    output logic [OUT_W-1:0]     m_axis_tdata
);

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_job front_job;
    t_job back_job;

    thv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_full      (full),
        .o_push      (push),
        .o_job       (front_job)
    );

    thv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (back_job)
    );

    thv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (back_job),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

FILE: hw/rtl/thv_front.sv
// ----------------------------------------------------------------------------
// thv_front
// Holds the configuration registers, takes header beats and runs the ordered
// header checks, handing each classified header to the job queue.
// ----------------------------------------------------------------------------
module thv_front
    import thv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [IN_W-1:0]      i_tdata,
    input  logic                 i_full,
    output logic                 o_push,
    output t_job                 o_job
);

    logic [31:0] r_magic_word;
    logic [31:0] r_format_version;
    logic [7:0]  r_highest_format;
    logic [7:0]  r_block_format_code;
    logic [7:0]  r_half_float_code;

    logic [63:0] file_bytes;
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] levels;
    logic [31:0] fmt;
    logic [31:0] cs;
    logic [31:0] faces;
    logic [63:0] declared;
    logic [31:0] big;
    logic [4:0]  lm1;
    logic        levels_bad;
    t_status     status;
    t_kind       kind;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word        <= 32'd0;
            r_format_version    <= 32'd0;
            r_highest_format    <= 8'd2;
            r_block_format_code <= 8'd2;
            r_half_float_code   <= 8'd1;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_MAGIC:   r_magic_word        <= i_cfg_data;
                REG_VERSION: r_format_version    <= i_cfg_data;
                REG_HIGHEST: r_highest_format    <= i_cfg_data[7:0];
                REG_BLOCK:   r_block_format_code <= i_cfg_data[7:0];
                REG_HALF:    r_half_float_code   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign file_bytes = i_tdata[63:0];
    assign magic      = i_tdata[95:64];
    assign version    = i_tdata[127:96];
    assign w          = i_tdata[159:128];
    assign h          = i_tdata[191:160];
    assign levels     = i_tdata[223:192];
    assign fmt        = i_tdata[255:224];
    assign cs         = i_tdata[287:256];
    assign faces      = i_tdata[319:288];
    assign declared   = i_tdata[383:320];

    // The full chain covers a level count n when the larger extent has bit n-1 or above set.
    assign big        = (w > h) ? w : h;
    assign lm1        = levels[4:0] - 5'd1;
    assign levels_bad = (levels > 32'd32) || ((big >> lm1) == 32'd0);

    always_comb begin
        if (file_bytes < 64'(HEADER_BYTES)) begin
            status = ST_SHORT;
        end else if (magic != r_magic_word) begin
            status = ST_MAGIC;
        end else if (version != r_format_version) begin
            status = ST_VERSION;
        end else if (w == 32'd0 || h == 32'd0 || levels == 32'd0) begin
            status = ST_EMPTY;
        end else if (fmt > {24'd0, r_highest_format} || cs > 32'd1) begin
            status = ST_FORMAT;
        end else if (faces != 32'd1 && faces != 32'(CUBE_FACES)) begin
            status = ST_FACES;
        end else if (faces == 32'(CUBE_FACES) && w != h) begin
            status = ST_SQUARE;
        end else if (levels_bad) begin
            status = ST_LEVELS;
        end else if (w > 32'(MAX_EXTENT) || h > 32'(MAX_EXTENT)) begin
            status = ST_LARGE;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        if (fmt == {24'd0, r_block_format_code}) begin
            kind = K_BLOCK;
        end else if (fmt == {24'd0, r_half_float_code}) begin
            kind = K_HALF;
        end else begin
            kind = K_PLAIN;
        end
    end

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    always_comb begin
        o_job.status   = status;
        o_job.kind     = kind;
        o_job.cube     = (faces == 32'(CUBE_FACES));
        o_job.levels   = (levels > 32'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : levels[LVL_W-1:0];
        o_job.width    = w[EXT_W-1:0];
        o_job.height   = h[EXT_W-1:0];
        o_job.have     = file_bytes - 64'(HEADER_BYTES);
        o_job.declared = declared;
    end

endmodule

FILE: hw/rtl/thv_queue.sv
// ----------------------------------------------------------------------------
// thv_queue
// Short job queue between the header checks and the size computation.
// ----------------------------------------------------------------------------
module thv_queue
    import thv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_count;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (do_pop && !i_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: hw/rtl/thv_back.sv
// ----------------------------------------------------------------------------
// thv_back
// Walks the mip chain of a passed header with one multiplier, scales the sum
// by the face count, compares it and holds the result beat for the output.
// ----------------------------------------------------------------------------
module thv_back
    import thv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [OUT_W-1:0]    o_tdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_SCALE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_job                r_job, n_job;
    logic [EXT_W-1:0]    r_w, n_w;
    logic [EXT_W-1:0]    r_h, n_h;
    logic [LVL_W-1:0]    r_left, n_left;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_pv, n_pv;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [WANT_W-1:0]   r_wanted, n_wanted;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [WANT_W-1:0]   r_out_wanted, n_out_wanted;

    logic [EXT_W-1:0]    op_a;
    logic [EXT_W-1:0]    op_b;
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    lvl_bytes;
    logic [EXT_W-1:0]    w_half;
    logic [EXT_W-1:0]    h_half;
    logic                out_free;
    logic                sizes_match;

    assign out_free = !r_out_valid || i_tready;

    always_comb begin
        if (r_job.kind == K_BLOCK) begin
            op_a = EXT_W'(({1'b0, r_w} + (EXT_W+1)'(BLOCK_EDGE - 1)) >> BLOCK_SHIFT);
            op_b = EXT_W'(({1'b0, r_h} + (EXT_W+1)'(BLOCK_EDGE - 1)) >> BLOCK_SHIFT);
        end else begin
            op_a = r_w;
            op_b = r_h;
        end
    end

    assign prod = op_a * op_b;

    always_comb begin
        case (r_job.kind)
            K_BLOCK: lvl_bytes = SUM_W'(r_prod) << BLOCK_BYTES_SHIFT;
            K_HALF:  lvl_bytes = SUM_W'(r_prod) << HALF_BYTES_SHIFT;
            default: lvl_bytes = SUM_W'(r_prod) << PLAIN_BYTES_SHIFT;
        endcase
    end

    assign w_half = (r_w[EXT_W-1:1] == '0) ? EXT_W'(1) : (r_w >> 1);
    assign h_half = (r_h[EXT_W-1:1] == '0) ? EXT_W'(1) : (r_h >> 1);

    assign sizes_match = (r_job.declared == 64'(r_wanted)) && (r_job.have == 64'(r_wanted));

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_w          = r_w;
        n_h          = r_h;
        n_left       = r_left;
        n_prod       = r_prod;
        n_pv         = r_pv;
        n_sum        = r_sum;
        n_wanted     = r_wanted;
        n_out_valid  = r_out_valid && !i_tready;
        n_out_status = r_out_status;
        n_out_wanted = r_out_wanted;
        o_pop        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop    = 1'b1;
                    n_job    = i_job;
                    n_w      = i_job.width;
                    n_h      = i_job.height;
                    n_left   = i_job.levels;
                    n_sum    = '0;
                    n_pv     = 1'b0;
                    n_wanted = '0;
                    n_state  = (i_job.status == ST_OK) ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                n_prod = prod;
                n_pv   = 1'b1;
                if (r_pv) begin
                    n_sum = r_sum + lvl_bytes;
                end
                n_w    = w_half;
                n_h    = h_half;
                n_left = r_left - LVL_W'(1);
                if (r_left == LVL_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_sum   = r_sum + lvl_bytes;
                n_pv    = 1'b0;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                if (r_job.cube) begin
                    n_wanted = (WANT_W'(r_sum) << 2) + (WANT_W'(r_sum) << 1);
                end else begin
                    n_wanted = WANT_W'(r_sum);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_wanted = r_wanted;
                    if (r_job.status != ST_OK) begin
                        n_out_status = r_job.status;
                    end else begin
                        n_out_status = sizes_match ? ST_OK : ST_SIZE;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_w          <= n_w;
        r_h          <= n_h;
        r_left       <= n_left;
        r_prod       <= n_prod;
        r_sum        <= n_sum;
        r_wanted     <= n_wanted;
        r_out_status <= n_out_status;
        r_out_wanted <= n_out_wanted;
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {(OUT_W - WANTED_W - STATUS_W)'(0), WANTED_W'(r_out_wanted), r_out_status};

endmodule

FILE: hw/rtl/thv_checker.sv
// ----------------------------------------------------------------------------
// thv_checker
// Port-level checks for the texture header validator, bound to the top level.
// ----------------------------------------------------------------------------
`include "texture_header_validator_unit_assert.svh"

module thv_checker
    import thv_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    `THV_ASSERT_RST(a_reset_clears_output, !m_axis_tvalid)

    `THV_ASSERT_IMP(a_status_in_range, m_axis_tvalid, m_axis_tdata[3:0] <= ST_SIZE)

    `THV_ASSERT_IMP(a_early_fail_no_bytes, m_axis_tvalid && m_axis_tdata[3:0] != ST_OK && m_axis_tdata[3:0] != ST_SIZE, m_axis_tdata[51:4] == 48'd0)

    `THV_ASSERT_NXT(a_stalled_beat_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind texture_header_validator_unit thv_checker u_thv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/tb_texture_header_validator_unit.sv
// ----------------------------------------------------------------------------
// tb_texture_header_validator_unit
// Self-checking bench for the texture header validator. Header beats go in
// on the input stream, and each one is run through a predictor of the
// check order and the mip-chain byte count. Every result beat is compared
// against the oldest prediction. The run starts with a directed pass over
// every status code at the reset settings. It then walks through several
// register settings with random headers, most of them built well formed and
// half of those broken in one field, under random idling on both streams and one long
// output stall.
// ----------------------------------------------------------------------------
module tb_texture_header_validator_unit;
    import thv_pkg::*;

    localparam int unsigned RUN_LIMIT = 800000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_SETTING = 215;
    localparam int SETTING_COUNT = 6;
    localparam int TAIL_CYCLES = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam logic [31:0] CS_SRGB = 32'd0;
    localparam logic [31:0] CS_LINEAR = 32'd1;
    localparam logic [31:0] SINGLE_FACE = 32'd1;
    localparam logic [31:0] DEFAULT_PLAIN_FMT = 32'd0;

    // Fields run from the highest bits down, so file_bytes lands in bits 63:0.
    typedef struct packed {
        logic [63:0] declared_payload;
        logic [31:0] faces;
        logic [31:0] color_space_code;
        logic [31:0] format_code;
        logic [31:0] level_count;
        logic [31:0] image_height;
        logic [31:0] image_width;
        logic [31:0] header_version;
        logic [31:0] header_magic;
        logic [63:0] file_bytes;
    } t_header;

    typedef struct packed {
        logic [WANTED_W-1:0] wanted;
        t_status             status;
    } t_verdict;

    typedef enum int {
        F_SHORT, F_MAGIC, F_VERSION, F_EMPTY, F_FORMAT, F_COLOR,
        F_FACES, F_SQUARE, F_LEVELS, F_LARGE, F_DECLARED, F_FILE
    } t_fault;

    class header_scoreboard;
        logic [31:0] magic_word;
        logic [31:0] format_version;
        logic [7:0]  highest_fmt;
        logic [7:0]  block_fmt;
        logic [7:0]  half_fmt;
        t_verdict    pending_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned status_seen[16];

        function new();
            magic_word = 32'd0;
            format_version = 32'd0;
            highest_fmt = 8'd2;
            block_fmt = 8'd2;
            half_fmt = 8'd1;
            mismatches = 0;
            checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_MAGIC:   magic_word = data;
                REG_VERSION: format_version = data;
                REG_HIGHEST: highest_fmt = data[7:0];
                REG_BLOCK:   block_fmt = data[7:0];
                REG_HALF:    half_fmt = data[7:0];
                default: ;
            endcase
        endfunction

        function int chain_length(logic [31:0] w, logic [31:0] h);
            logic [31:0] big;
            int n;
            n = 0;
            if (w == 0 || h == 0) return 0;
            big = (w > h) ? w : h;
            while (big != 0) begin
                big = big >> 1;
                n++;
            end
            return n;
        endfunction

        function logic [63:0] bytes_of_level(logic [31:0] fmt, logic [63:0] w, logic [63:0] h);
            if (fmt == {24'd0, block_fmt}) begin
                return ((w + BLOCK_EDGE - 1) / BLOCK_EDGE) * ((h + BLOCK_EDGE - 1) / BLOCK_EDGE)
                       * 64'd16;
            end
            return w * h * ((fmt == {24'd0, half_fmt}) ? 64'd8 : 64'd4);
        endfunction

        function t_verdict predict(t_header h);
            t_verdict r;
            logic [63:0] sum;
            logic [63:0] total;
            logic [63:0] lw;
            logic [63:0] lh;
            int lvl;
            r.wanted = '0;
            if (h.file_bytes < HEADER_BYTES)
                r.status = ST_SHORT;
            else if (h.header_magic != magic_word)
                r.status = ST_MAGIC;
            else if (h.header_version != format_version)
                r.status = ST_VERSION;
            else if (h.image_width == 0 || h.image_height == 0 || h.level_count == 0)
                r.status = ST_EMPTY;
            else if (h.format_code > {24'd0, highest_fmt} || h.color_space_code > CS_LINEAR)
                r.status = ST_FORMAT;
            else if (h.faces != SINGLE_FACE && h.faces != CUBE_FACES)
                r.status = ST_FACES;
            else if (h.faces == CUBE_FACES && h.image_width != h.image_height)
                r.status = ST_SQUARE;
            else if (h.level_count > chain_length(h.image_width, h.image_height))
                r.status = ST_LEVELS;
            else if (h.image_width > MAX_EXTENT || h.image_height > MAX_EXTENT)
                r.status = ST_LARGE;
            else begin
                sum = '0;
                for (lvl = 0; lvl < MAX_LEVELS && lvl < h.level_count; lvl++) begin
                    lw = {32'd0, h.image_width} >> lvl;
                    lh = {32'd0, h.image_height} >> lvl;
                    if (lw == 0) lw = 1;
                    if (lh == 0) lh = 1;
                    sum = sum + bytes_of_level(h.format_code, lw, lh);
                end
                total = sum * {32'd0, h.faces};
                r.wanted = total[WANTED_W-1:0];
                if (h.declared_payload != total || h.file_bytes - HEADER_BYTES != total)
                    r.status = ST_SIZE;
                else
                    r.status = ST_OK;
            end
            return r;
        endfunction

        function void note_header(t_header h);
            pending_q.push_back(predict(h));
        endfunction

        function void check_verdict(logic [OUT_W-1:0] beat);
            t_verdict got;
            t_verdict want;
            got = t_verdict'(beat[STATUS_W+WANTED_W-1:0]);
            if (pending_q.size() == 0) begin
                $error("result beat with no header pending: status %0d, wanted_bytes %0d",
                       got.status, got.wanted);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            status_seen[int'(want.status)]++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.wanted !== want.wanted) begin
                $error("wanted_bytes: expected %0d, actual %0d", want.wanted, got.wanted);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;

    header_scoreboard sb;
    bit calm = 1'b0;
    bit squeeze = 1'b0;
    int unsigned cycle_count = 0;
    int stall_left = 0;

    texture_header_validator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb_texture_header_validator_unit failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
    end

    function automatic int gap_len();
        int roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 99) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    initial begin : result_sink
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                squeeze = 1'b0;
            end else if (calm || stall_left == 0) begin
                m_axis_tready <= 1'b1;
                stall_left = calm ? 0 : gap_len();
            end else begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    function automatic logic [31:0] pick_extent();
        int roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 40);
        if (roll < 95) return $urandom_range(1, 600);
        if (roll < 99) return $urandom_range(1, MAX_EXTENT);
        return MAX_EXTENT;
    endfunction

    function automatic logic [31:0] pick_format();
        logic [31:0] fmt;
        case ($urandom_range(0, 2))
            0: fmt = {24'd0, sb.block_fmt};
            1: fmt = {24'd0, sb.half_fmt};
            default: fmt = $urandom_range(0, sb.highest_fmt);
        endcase
        if (fmt > sb.highest_fmt) fmt = $urandom_range(0, sb.highest_fmt);
        return fmt;
    endfunction

    function automatic t_header good_header(logic [31:0] w, logic [31:0] ht, logic [31:0] lv,
                                            logic [31:0] fmt, logic [31:0] cs,
                                            logic [31:0] faces);
        t_header h;
        t_verdict v;
        h.header_magic = sb.magic_word;
        h.header_version = sb.format_version;
        h.image_width = w;
        h.image_height = ht;
        h.level_count = lv;
        h.format_code = fmt;
        h.color_space_code = cs;
        h.faces = faces;
        h.declared_payload = '0;
        h.file_bytes = HEADER_BYTES;
        v = sb.predict(h);
        h.declared_payload = {16'd0, v.wanted};
        h.file_bytes = {16'd0, v.wanted} + HEADER_BYTES;
        return h;
    endfunction

    function automatic t_header random_header();
        t_header h;
        logic [31:0] w;
        logic [31:0] ht;
        logic [31:0] faces;
        int chain;
        int roll;
        t_fault fault;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            for (int i = 0; i < IN_W / 32; i++) h[i*32 +: 32] = $urandom;
            if ($urandom_range(0, 1)) h.header_magic = sb.magic_word;
            if ($urandom_range(0, 1)) h.header_version = sb.format_version;
            return h;
        end
        faces = ($urandom_range(0, 3) == 0) ? CUBE_FACES : SINGLE_FACE;
        w = pick_extent();
        ht = (faces == CUBE_FACES) ? w : pick_extent();
        chain = sb.chain_length(w, ht);
        h = good_header(w, ht, $urandom_range(1, chain), pick_format(),
                        $urandom_range(0, 1), faces);
        if (roll < 55) return h;
        fault = t_fault'($urandom_range(F_SHORT, F_FILE));
        case (fault)
            F_SHORT:   h.file_bytes = $urandom_range(0, HEADER_BYTES - 1);
            F_MAGIC:   h.header_magic = h.header_magic ^ ($urandom | 32'd1);
            F_VERSION: h.header_version = h.header_version ^ ($urandom | 32'd1);
            F_EMPTY: begin
                case ($urandom_range(0, 2))
                    0: h.image_width = '0;
                    1: h.image_height = '0;
                    default: h.level_count = '0;
                endcase
            end
            F_FORMAT:  h.format_code = $urandom_range({24'd0, sb.highest_fmt} + 1, 32'hFFFF_FFFF);
            F_COLOR:   h.color_space_code = $urandom_range(2, 32'hFFFF_FFFF);
            F_FACES: begin
                case ($urandom_range(0, 2))
                    0: h.faces = '0;
                    1: h.faces = $urandom_range(2, 5);
                    default: h.faces = $urandom_range(7, 32'hFFFF_FFFF);
                endcase
            end
            F_SQUARE: begin
                h.faces = CUBE_FACES;
                if ($urandom_range(0, 1))
                    h.image_height = h.image_width + $urandom_range(1, 50);
                else
                    h.image_width = h.image_height + $urandom_range(1, 50);
            end
            F_LEVELS: begin
                if ($urandom_range(0, 1))
                    h.level_count = chain + $urandom_range(1, 4);
                else
                    h.level_count = $urandom_range(chain + 1, 32'hFFFF_FFFF);
            end
            F_LARGE: begin
                h.faces = SINGLE_FACE;
                if ($urandom_range(0, 1))
                    h.image_width = $urandom_range(MAX_EXTENT + 1, 32'hFFFF_FFFF);
                else
                    h.image_height = $urandom_range(MAX_EXTENT + 1, 32'hFFFF_FFFF);
            end
            F_DECLARED: h.declared_payload = h.declared_payload ^ (64'd1 << $urandom_range(0, 63));
            default:    h.file_bytes = h.file_bytes ^ (64'd1 << $urandom_range(0, 63));
        endcase
        return h;
    endfunction

    function automatic logic [31:0] with_noise(logic [7:0] code);
        return ($urandom & 32'hFFFF_FF00) | {24'd0, code};
    endfunction

    task automatic send_header(input t_header h);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= h;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_header(h);
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input int phase);
        case (phase)
            1: begin
                write_setting(REG_MAGIC, 32'hFFFF_FFFF);
                write_setting(REG_VERSION, 32'hFFFF_FFFF);
                write_setting(REG_HIGHEST, with_noise(8'd255));
                write_setting(REG_BLOCK, with_noise(8'd255));
                write_setting(REG_HALF, with_noise(8'd0));
            end
            2: begin
                write_setting(REG_MAGIC, $urandom);
                write_setting(REG_VERSION, 32'd0);
                write_setting(REG_HIGHEST, with_noise(8'd0));
                write_setting(REG_BLOCK, with_noise(8'd0));
                write_setting(REG_HALF, with_noise(8'd0));
            end
            3: begin
                write_setting(REG_MAGIC, $urandom);
                write_setting(REG_VERSION, $urandom);
                write_setting(REG_HIGHEST, with_noise(8'd7));
                write_setting(REG_BLOCK, with_noise(8'd5));
                write_setting(REG_HALF, with_noise(8'd5));
            end
            4: begin
                write_setting(REG_MAGIC, 32'd0);
                write_setting(REG_VERSION, $urandom);
                write_setting(REG_HIGHEST, with_noise(8'd1));
                write_setting(REG_BLOCK, with_noise(8'd200));
                write_setting(REG_HALF, with_noise(8'd1));
            end
            5: begin
                write_setting(REG_HIGHEST, $urandom);
                write_setting(REG_BLOCK, $urandom);
                write_setting(REG_HALF, $urandom);
                write_setting(REG_MAGIC, $urandom);
                write_setting(REG_VERSION, $urandom);
                write_setting(CFG_SPARE_IDX, $urandom);
            end
            default: begin
                write_setting(REG_MAGIC, $urandom);
                write_setting(REG_VERSION, $urandom);
                write_setting(REG_HIGHEST, with_noise(8'd2));
                write_setting(REG_BLOCK, with_noise(8'd2));
                write_setting(REG_HALF, with_noise(8'd1));
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        t_header base;
        t_header h;
        logic [31:0] blk;
        logic [31:0] half;
        blk = {24'd0, sb.block_fmt};
        half = {24'd0, sb.half_fmt};
        send_header(good_header(1, 1, 1, DEFAULT_PLAIN_FMT, CS_SRGB, SINGLE_FACE));
        send_header(good_header(7, 5, 3, half, CS_LINEAR, SINGLE_FACE));
        send_header(good_header(13, 9, 4, blk, CS_SRGB, SINGLE_FACE));
        send_header(good_header(16, 16, 5, blk, CS_LINEAR, CUBE_FACES));
        send_header(good_header(MAX_EXTENT, MAX_EXTENT, MAX_LEVELS, half, CS_SRGB, CUBE_FACES));
        send_header(good_header(MAX_EXTENT, 1, MAX_LEVELS, blk, CS_LINEAR, SINGLE_FACE));
        base = good_header(4, 4, 3, DEFAULT_PLAIN_FMT, CS_SRGB, SINGLE_FACE);
        h = base; h.file_bytes = HEADER_BYTES - 1;           send_header(h);
        h = base; h.file_bytes = HEADER_BYTES;               send_header(h);
        h = base; h.header_magic = ~sb.magic_word;           send_header(h);
        h = base; h.header_version = sb.format_version + 1;  send_header(h);
        h = base; h.image_width = '0;                        send_header(h);
        h = base; h.image_height = '0;                       send_header(h);
        h = base; h.level_count = '0;                        send_header(h);
        h = base; h.format_code = {24'd0, sb.highest_fmt} + 1; send_header(h);
        h = base; h.format_code = 32'hFFFF_FFFF;             send_header(h);
        h = base; h.color_space_code = 32'd2;                send_header(h);
        h = base; h.color_space_code = 32'hFFFF_FFFF;        send_header(h);
        h = base; h.faces = '0;                              send_header(h);
        h = base; h.faces = 32'hFFFF_FFFF;                   send_header(h);
        h = good_header(8, 8, 4, blk, CS_SRGB, CUBE_FACES);
        h.image_height = 32'd4;                              send_header(h);
        h = base; h.level_count = 32'd4;                     send_header(h);
        h = base; h.level_count = 32'hFFFF_FFFF;             send_header(h);
        h = good_header(MAX_EXTENT + 1, 1, 1, half, CS_SRGB, SINGLE_FACE);
        send_header(h);
        h = base; h.image_width = 32'hFFFF_FFFF; h.image_height = 32'hFFFF_FFFF;
        h.level_count = 32'd32;                              send_header(h);
        h = base; h.declared_payload = base.declared_payload + 1; send_header(h);
        h = base; h.declared_payload = 64'hFFFF_FFFF_FFFF_FFFF;   send_header(h);
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        int distinct;
        sb = new();
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_MAGIC;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int phase = 1; phase <= SETTING_COUNT; phase++) begin
            drain();
            apply_setting(phase);
            calm = (phase == 2);
            squeeze = (phase == 2);
            repeat (ITEMS_PER_SETTING) send_header(random_header());
            s_axis_tvalid <= 1'b0;
        end
        drain();
        calm = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        distinct = 0;
        foreach (sb.status_seen[i]) if (sb.status_seen[i] != 0) distinct++;
        $display("Checked %0d headers over %0d register settings: %0d accepted, %0d size mismatches.",
                 sb.checked, SETTING_COUNT + 1, sb.status_seen[ST_OK], sb.status_seen[ST_SIZE]);
        $display("%0d distinct status codes were returned, with %0d early rejections in all.",
                 distinct, sb.checked - sb.status_seen[ST_OK] - sb.status_seen[ST_SIZE]);
        if (sb.mismatches == 0) begin
            $display("tb_texture_header_validator_unit passed");
        end else begin
            $display("tb_texture_header_validator_unit failed");
        end
        $finish;
    end

endmodule
